### rtl/i2cbs_pkg.sv
// Package for the I2C master bit sequencer: command codes, phase numbers,
// sequencer state and result types. No dependencies.
`default_nettype none

package i2cbs_pkg;

    localparam int BITS_PER_BYTE = 8;

    localparam logic [3:0]  LAST_BIT          = 4'(BITS_PER_BYTE - 1);
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd4;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_ACK   = 3'd3,
        OP_NOACK = 3'd4,
        OP_TEST  = 3'd5,
        OP_WRITE = 3'd6,
        OP_READ  = 3'd7
    } t_op;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_THIRD  = 3'd2;
    localparam logic [2:0] PH_FOURTH = 3'd3;

    typedef struct packed {
        logic        scl;
        logic        sda;
        t_op         cmd;
        logic [2:0]  phase;
        logic [3:0]  bit_cnt;
        logic [15:0] delay;
        logic [7:0]  tx_shift;
        logic [7:0]  rx_shift;
        logic        ack_flag;
    } t_state;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       no_ack;
    } t_result;

endpackage

`default_nettype wire

### rtl/i2cbs_if.sv
// Valid/ready channel interfaces for the I2C master bit sequencer:
// command/tick channel and result channel. No dependencies.
`default_nettype none

interface i2cbs_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output operation, output tx_byte, output sda_in,
                    input ready);
    modport sink   (input valid, input operation, input tx_byte, input sda_in,
                    output ready);
endinterface

interface i2cbs_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output done_res, output rx_byte, output no_ack, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input done_res, input rx_byte, input no_ack, output ready);
endinterface

`default_nettype wire

### rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one transaction on the command channel is one tick and
// gives exactly one result transaction. While idle a non-zero operation starts a
// command (start, stop, ack, no-ack, test ack, write byte, read byte) which runs as a
// list of pin phases, most held for phase_ticks ticks (zero counts as one); the last
// no-ack/test phase and the non-SCL-high read phases take one tick. The block takes
// one transaction per clock: a command register feeds the tick logic, whose
// outcome lands in the result register; only a stalled result channel slows the
// input. phase_ticks is written on i_cfg_we and should only change while no
// command is running. Depends on i2cbs_pkg, i2cbs_if and i2cbs_step.
`default_nettype none

module i2c_master_bit_sequencer
    import i2cbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    i2cbs_cmd_if.sink        i_cmd,
    i2cbs_res_if.source      o_res
);

    logic [15:0] r_phase_ticks;
    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic [7:0]  r_in_tx;
    logic        r_in_sda;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        w_adv;
    logic        w_in_acc;

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_adv;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;

    i2cbs_step u_step (
        .i_state       (r_state),
        .i_operation   (r_in_op),
        .i_tx_byte     (r_in_tx),
        .i_sda_in      (r_in_sda),
        .i_phase_ticks (r_phase_ticks),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op  <= i_cmd.operation;
            r_in_tx  <= i_cmd.tx_byte;
            r_in_sda <= i_cmd.sda_in;
        end
    end

    // sequencer state moves only when a tick is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{scl: 1'b1, sda: 1'b1, cmd: OP_IDLE, phase: 3'd0, bit_cnt: 4'd0,
                         delay: 16'd0, tx_shift: 8'd0, rx_shift: 8'd0, ack_flag: 1'b0};
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_out.scl_level;
    assign o_res.sda_level = r_out.sda_level;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.rx_byte   = r_out.rx_byte;
    assign o_res.no_ack    = r_out.no_ack;

endmodule

`default_nettype wire

### rtl/i2cbs_step.sv
// Next-state and result logic for one tick of the I2C bit sequencer.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_step
    import i2cbs_pkg::*;
(
    input  t_state      i_state,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_sda_in,
    input  logic [15:0] i_phase_ticks,
    output t_state      o_state,
    output t_result     o_result
);

    t_state s;
    t_op    op;
    logic   busy;
    logic   done;
    logic   enter;
    logic   held;
    logic   final_ph;

    always_comb begin
        s     = i_state;
        op    = t_op'(i_operation);
        busy  = 1'b0;
        done  = 1'b0;
        enter = 1'b0;

        if (s.cmd == OP_IDLE) begin
            if (op != OP_IDLE) begin
                s.cmd     = op;
                s.phase   = PH_FIRST;
                s.bit_cnt = 4'd0;
                if (op == OP_WRITE) s.tx_shift = i_tx_byte;
                if (op == OP_READ)  s.rx_shift = 8'd0;
                enter = 1'b1;
                busy  = 1'b1;
            end
        end else begin
            busy = 1'b1;
            if (s.delay != 16'd0) begin
                s.delay = s.delay - 16'd1;
            end else begin
                // advance to the next phase; byte commands loop per bit
                if (s.cmd == OP_WRITE && s.phase == PH_THIRD) begin
                    s.phase    = PH_FIRST;
                    s.bit_cnt  = s.bit_cnt + 4'd1;
                    s.tx_shift = {s.tx_shift[6:0], 1'b0};
                end else if (s.cmd == OP_READ && s.phase == PH_THIRD) begin
                    s.phase   = PH_SECOND;
                    s.bit_cnt = s.bit_cnt + 4'd1;
                end else begin
                    s.phase = s.phase + 3'd1;
                end
                enter = 1'b1;
            end
        end

        if (enter) begin
            unique case (s.cmd)
                OP_START: begin
                    if (s.phase == PH_FIRST)       s.sda = 1'b1;
                    else if (s.phase == PH_SECOND) s.scl = 1'b1;
                    else if (s.phase == PH_THIRD)  s.sda = 1'b0;
                    else                           s.scl = 1'b0;
                end
                OP_STOP: begin
                    if (s.phase == PH_FIRST)       s.scl = 1'b0;
                    else if (s.phase == PH_SECOND) s.sda = 1'b0;
                    else if (s.phase == PH_THIRD)  s.scl = 1'b1;
                    else                           s.sda = 1'b1;
                end
                OP_ACK: begin
                    if (s.phase == PH_FIRST)       s.sda = 1'b0;
                    else if (s.phase == PH_SECOND) s.scl = 1'b1;
                    else if (s.phase == PH_THIRD)  s.scl = 1'b0;
                    else                           s.sda = 1'b1;
                end
                OP_NOACK: begin
                    if (s.phase == PH_FIRST)       s.sda = 1'b1;
                    else if (s.phase == PH_SECOND) s.scl = 1'b1;
                    else if (s.phase == PH_THIRD)  s.scl = 1'b0;
                    else                           s.sda = 1'b0;
                end
                OP_TEST: begin
                    if (s.phase == PH_FIRST)       s.sda = 1'b1;
                    else if (s.phase == PH_SECOND) s.scl = 1'b1;
                    else if (s.phase == PH_THIRD)  s.ack_flag = i_sda_in;
                    else                           s.scl = 1'b0;
                end
                OP_WRITE: begin
                    if (s.phase == PH_FIRST)       s.sda = s.tx_shift[7];
                    else if (s.phase == PH_SECOND) s.scl = 1'b1;
                    else                           s.scl = 1'b0;
                end
                OP_READ: begin
                    if (s.phase == PH_FIRST) begin
                        s.sda = 1'b1;
                    end else if (s.phase == PH_SECOND) begin
                        s.scl = 1'b1;
                    end else begin
                        s.rx_shift = {s.rx_shift[6:0], i_sda_in};
                        s.scl      = 1'b0;
                    end
                end
                OP_IDLE: begin
                end
                default: begin
                end
            endcase

            held = !(((s.cmd == OP_NOACK) || (s.cmd == OP_TEST)) && s.phase == PH_FOURTH)
                && !((s.cmd == OP_READ) && s.phase != PH_SECOND);
            // a zero hold counts as one tick
            if (held && i_phase_ticks != 16'd0) s.delay = i_phase_ticks - 16'd1;
            else                                s.delay = 16'd0;
        end else begin
            held = 1'b0;
        end

        if (s.cmd == OP_WRITE || s.cmd == OP_READ)
            final_ph = (s.phase == PH_THIRD) && (s.bit_cnt == LAST_BIT);
        else
            final_ph = (s.phase == PH_FOURTH);

        if (busy && s.delay == 16'd0 && final_ph) begin
            done      = 1'b1;
            s.cmd     = OP_IDLE;
            s.phase   = PH_FIRST;
            s.bit_cnt = 4'd0;
        end

        o_state            = s;
        o_result.scl_level = s.scl;
        o_result.sda_level = s.sda;
        o_result.busy_res  = busy;
        o_result.done_res  = done;
        o_result.rx_byte   = s.rx_shift;
        o_result.no_ack    = s.ack_flag;
    end

endmodule

`default_nettype wire

### rtl/i2cbs_checker.sv
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on i2c_master_bit_sequencer and the channel interfaces.
`default_nettype none

module i2cbs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_scl,
    input wire logic       i_sda,
    input wire logic       i_busy,
    input wire logic       i_done,
    input wire logic [7:0] i_rx_byte,
    input wire logic       i_no_ack
);

    // a finished command is always part of a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_done || i_busy))
        else $error("done without busy");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_scl) && $stable(i_sda) && $stable(i_busy)
             && $stable(i_done) && $stable(i_rx_byte) && $stable(i_no_ack)))
        else $error("stalled result changed");

    // input side frees up whenever the result side is free
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with result side free");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_scl       (o_res.scl_level),
    .i_sda       (o_res.sda_level),
    .i_busy      (o_res.busy_res),
    .i_done      (o_res.done_res),
    .i_rx_byte   (o_res.rx_byte),
    .i_no_ack    (o_res.no_ack)
);

`default_nettype wire
